>>> sv/eais_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expert adapter index scatter package
// Shared widths, codes, default sizes and the divider handshake types.
// ----------------------------------------------------------------------------
package eais_pkg;

    localparam int ROWS_DEFAULT     = 1024;
    localparam int ADAPTERS_DEFAULT = 64;
    localparam int TOKEN_DEPTH      = 1024;

    localparam int ACTION_W  = 2;
    localparam int TOKEN_W   = 10;
    localparam int SLOT_W    = 8;
    localparam int DEST_W    = 11;
    localparam int EXPERT_W  = 10;
    localparam int READ_W    = 10;
    localparam int ROUTE_W   = 17;
    localparam int ROW_W     = 10;
    localparam int K_W       = 7;
    localparam int ACOUNT_W  = 7;
    localparam int ECOUNT_W  = 11;
    localparam int MASK_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    // Wide enough to compare any position against any store depth.
    localparam int POS_W     = 13;

    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ROW  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ADAPTER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_K         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPERT_COUNT  = 2'd3;

    localparam logic [ROUTE_W-1:0] NO_ROUTE  = '1;
    localparam logic [18:0]        ROUTE_MAX = 19'd65535;

    typedef struct packed {
        logic             start;
        logic [ROW_W-1:0] dividend;
        logic [K_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ROW_W-1:0] quotient;
        logic [K_W-1:0]   remainder;
    } div_status_t;

endpackage

>>> sv/eais_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expert adapter index scatter row divider
// Restoring divider, one quotient bit per cycle, for the row-to-token split.
// ----------------------------------------------------------------------------
module eais_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  eais_pkg::div_req_t   req,
    output eais_pkg::div_status_t status
);
    import eais_pkg::*;

    localparam int STEPS = ROW_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [ROW_W-1:0] dvd_reg, dvd_next;
    logic [K_W-1:0]   rem_reg, rem_next;
    logic [K_W-1:0]   dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [K_W:0]     trial;
    logic             fits;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[ROW_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? K_W'(trial - {1'b0, dvs_reg}) : trial[K_W-1:0];
        dvd_next = {dvd_reg[ROW_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // Done pulses for one cycle after the last quotient bit.
            done_reg <= !req.start && busy_reg && (cnt_reg == CNT_W'(STEPS - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy      = busy_reg | done_reg;
    assign status.done      = done_reg;
    assign status.quotient  = dvd_reg;
    assign status.remainder = rem_reg;

endmodule

>>> sv/expert_adapter_index_scatter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expert adapter index scatter
// Scatters a combined adapter/expert routing index to each row's destination.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                    Transfer when
//  --------  -----------------------------------------  ----------------------
//  command   start, busy, action, token_index, ...      start && !busy
//  result    result_valid, routed_index                 result_valid (1 cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
//  A load command writes the token table when taken. A row command reads the
//  token table when taken and holds busy in the next cycle, where the index is
//  formed and written to the result store. A read command shows its result in
//  the cycle after it is taken and does not hold off the next command. A write
//  to top_k starts the row divider, which keeps busy high until token and
//  offset are rebuilt. Reset clears the control state and sets the registers
//  to defaults; the two memories hold nothing until written. The receiver cannot stall results.
//
module expert_adapter_index_scatter_top #(
    parameter int ROWS     = eais_pkg::ROWS_DEFAULT,
    parameter int ADAPTERS = eais_pkg::ADAPTERS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [eais_pkg::ACTION_W-1:0]         action,
    input  logic [eais_pkg::TOKEN_W-1:0]          token_index,
    input  logic signed [eais_pkg::SLOT_W-1:0]    adapter_slot,
    input  logic signed [eais_pkg::DEST_W-1:0]    dest_position,
    input  logic [eais_pkg::EXPERT_W-1:0]         expert_id,
    input  logic                                  final_row,
    input  logic [eais_pkg::READ_W-1:0]           read_position,
    output logic                                  result_valid,
    output logic signed [eais_pkg::ROUTE_W-1:0]   routed_index,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [eais_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [eais_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import eais_pkg::*;

    localparam int AW = $clog2(ROWS);
    localparam int TW = $clog2(TOKEN_DEPTH);

    // Configuration registers.
    logic [ACOUNT_W-1:0] adapter_count_reg;
    logic [MASK_W-1:0]   enable_mask_reg;
    logic [K_W-1:0]      top_k_reg;
    logic [ECOUNT_W-1:0] expert_count_reg;

    // Row numbering, kept as row = token * k + offset so no divide is needed
    // per row; the divider rebuilds token and offset when top_k changes.
    logic [ROW_W-1:0] row_cnt_reg;
    logic [TW-1:0]    tok_reg;
    logic [K_W-1:0]   ofs_reg;
    logic [K_W-1:0]   k_eff;

    // Row in flight and read in flight.
    logic                row_phase_reg;
    logic                rd_phase_reg;
    logic                dest_ok_reg;
    logic [AW-1:0]       dest_addr_reg;
    logic [EXPERT_W-1:0] expert_reg;
    logic                rd_oob_reg;

    // Memories.
    logic [SLOT_W-1:0]  token_table [TOKEN_DEPTH];
    logic [ROUTE_W-1:0] result_store [ROWS];
    logic [SLOT_W-1:0]  slot_rd_reg;
    logic [ROUTE_W-1:0] store_rd_reg;

    logic        accept;
    logic        cfg_take;
    div_req_t    div_req;
    div_status_t div_status;

    logic [DEST_W-1:0] dest_abs;
    logic [POS_W-1:0]  dest_ext;
    logic [POS_W-1:0]  read_ext;
    logic              read_ok;

    logic [K_W-1:0]     slot_low;
    logic               slot_valid;
    logic [17:0]        product;
    logic [18:0]        sum;
    logic [ROUTE_W-1:0] route_value;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign busy      = row_phase_reg | div_status.busy;
    assign k_eff     = (top_k_reg == '0) ? K_W'(1) : top_k_reg;

    // A write to top_k re-derives token and offset from the current row count.
    always_comb
    begin
        div_req.start    = cfg_take && (cfg_index == REG_TOP_K);
        div_req.dividend = row_cnt_reg;
        div_req.divisor  = (cfg_data[K_W-1:0] == '0) ? K_W'(1) : cfg_data[K_W-1:0];
    end

    eais_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (div_req),
        .status (div_status)
    );

    // The absolute value of an 11-bit destination fits 11 unsigned bits.
    always_comb
    begin
        dest_abs = dest_position[DEST_W-1] ? DEST_W'(~dest_position + 1'b1)
                                           : DEST_W'(dest_position);
        dest_ext = {{(POS_W-DEST_W){1'b0}}, dest_abs};
        read_ext = {{(POS_W-READ_W){1'b0}}, read_position};
        read_ok  = (read_ext < POS_W'(ROWS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adapter_count_reg <= ACOUNT_W'(64);
            enable_mask_reg   <= '0;
            top_k_reg         <= K_W'(1);
            expert_count_reg  <= ECOUNT_W'(1);
        end
        else if (cfg_take)
        begin
            unique case (cfg_index)
                REG_ADAPTER_COUNT: adapter_count_reg <= cfg_data[ACOUNT_W-1:0];
                REG_ENABLE_MASK:   enable_mask_reg   <= cfg_data[MASK_W-1:0];
                REG_TOP_K:         top_k_reg         <= cfg_data[K_W-1:0];
                REG_EXPERT_COUNT:  expert_count_reg  <= cfg_data[ECOUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            tok_reg       <= '0;
            ofs_reg       <= '0;
            row_phase_reg <= 1'b0;
            rd_phase_reg  <= 1'b0;
        end
        else
        begin
            row_phase_reg <= accept && (action == ACT_ROW);
            rd_phase_reg  <= accept && (action == ACT_READ);
            if (div_status.done)
            begin
                tok_reg <= TW'(div_status.quotient);
                ofs_reg <= div_status.remainder;
            end
            else if (accept && (action == ACT_ROW))
            begin
                // The last row and the counter wrap both start over at zero.
                if (final_row || (row_cnt_reg == ROW_W'(TOKEN_DEPTH - 1)))
                begin
                    row_cnt_reg <= '0;
                    tok_reg     <= '0;
                    ofs_reg     <= '0;
                end
                else
                begin
                    row_cnt_reg <= row_cnt_reg + 1'b1;
                    if (ofs_reg + K_W'(1) == k_eff)
                    begin
                        ofs_reg <= '0;
                        tok_reg <= tok_reg + 1'b1;
                    end
                    else
                    begin
                        ofs_reg <= ofs_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Row payload held for the result store write, and the out-of-range flag of a read.
    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_ROW))
        begin
            dest_ok_reg   <= (dest_ext < POS_W'(ROWS));
            dest_addr_reg <= dest_ext[AW-1:0];
            expert_reg    <= expert_id;
        end
        if (accept && (action == ACT_READ))
        begin
            rd_oob_reg <= !read_ok;
        end
    end

    // Token table: written by loads, read at the row's token.
    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_LOAD))
        begin
            token_table[token_index] <= adapter_slot;
        end
        if (accept && (action == ACT_ROW))
        begin
            slot_rd_reg <= token_table[tok_reg];
        end
    end

    // Route value formed from the token's slot as read for the row in flight.
    always_comb
    begin
        slot_low   = slot_rd_reg[K_W-1:0];
        slot_valid = !slot_rd_reg[SLOT_W-1]
                     && (slot_low < adapter_count_reg)
                     && ({1'b0, slot_low} < (K_W+1)'(ADAPTERS))
                     && enable_mask_reg[slot_low[5:0]];
        product    = {11'b0, slot_low} * {7'b0, expert_count_reg};
        sum        = {1'b0, product} + {9'b0, expert_reg};
        if (!slot_valid)
        begin
            route_value = NO_ROUTE;
        end
        else if (sum > ROUTE_MAX)
        begin
            route_value = ROUTE_W'(ROUTE_MAX);
        end
        else
        begin
            route_value = sum[ROUTE_W-1:0];
        end
    end

    // Result store: at most one write per row, one read per read command.
    always_ff @(posedge clk)
    begin
        if (row_phase_reg && dest_ok_reg)
        begin
            result_store[dest_addr_reg] <= route_value;
        end
        if (accept && (action == ACT_READ))
        begin
            store_rd_reg <= result_store[read_ext[AW-1:0]];
        end
    end

    assign result_valid = rd_phase_reg;
    assign routed_index = rd_oob_reg ? NO_ROUTE : store_rd_reg;

endmodule

>>> dv/tb_expert_adapter_index_scatter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expert adapter index scatter testbench
// Sends adapter loads, row commands, store reads, unused action codes and
// register writes to the scatter block. A behavioral predictor keeps its own
// adapter table, row counter and result store, and each returned routing
// index is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_expert_adapter_index_scatter_top;

    import eais_pkg::*;

    localparam int DUT_ROWS     = ROWS_DEFAULT;
    localparam int DUT_ADAPTERS = ADAPTERS_DEFAULT;

    // The fourth action code has no meaning. The block must ignore it.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // A row command writes its result, and a read result shows up, in the cycle after
    // its transfer. After this many quiet cycles the block has nothing in flight.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 2000;

    // One entry of the command backlog. It holds either a register write or a
    // command. Fields that the action does not use carry random filler.
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [ACTION_W-1:0]   act;
        logic [TOKEN_W-1:0]    tok;
        logic [SLOT_W-1:0]     slot;
        logic [DEST_W-1:0]     dest;
        logic [EXPERT_W-1:0]   expert;
        logic                  last;
        logic [READ_W-1:0]     rd_pos;
        int                    gap_pct;
    } work_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                        start         = 1'b0;
    logic                        busy;
    logic [ACTION_W-1:0]         action        = ACT_LOAD;
    logic [TOKEN_W-1:0]          token_index   = '0;
    logic signed [SLOT_W-1:0]    adapter_slot  = '0;
    logic signed [DEST_W-1:0]    dest_position = '0;
    logic [EXPERT_W-1:0]         expert_id     = '0;
    logic                        final_row     = 1'b0;
    logic [READ_W-1:0]           read_position = '0;
    logic                        result_valid;
    logic signed [ROUTE_W-1:0]   routed_index;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index     = '0;
    logic [CFG_DATA_W-1:0]       cfg_data      = '0;

    always #6 clk = ~clk;

    expert_adapter_index_scatter_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .token_index   (token_index),
        .adapter_slot  (adapter_slot),
        .dest_position (dest_position),
        .expert_id     (expert_id),
        .final_row     (final_row),
        .read_position (read_position),
        .result_valid  (result_valid),
        .routed_index  (routed_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // A command transfer happens at a rising edge where start is high and busy
    // is low. The always blocks read this before the edge's updates land.
    wire cmd_fire = start && !busy;

    // ------------------------------------------------------------------------
    // Predictor state. It starts at the reset values of the registers. The
    // table and the store are never read before the stimulus writes them.
    // ------------------------------------------------------------------------
    logic [ACOUNT_W-1:0]       cur_adapter_count = 7'd64;
    logic [MASK_W-1:0]         cur_enable_mask   = '0;
    logic [K_W-1:0]            cur_top_k         = 7'd1;
    logic [ECOUNT_W-1:0]       cur_expert_count  = 11'd1;
    logic signed [SLOT_W-1:0]  token_slot [TOKEN_DEPTH];
    logic signed [ROUTE_W-1:0] scattered [DUT_ROWS];
    logic [ROW_W-1:0]          row_num = '0;

    // Routing indexes that reads have asked for, oldest first.
    logic signed [ROUTE_W-1:0] routes_due [$];
    logic signed [ROUTE_W-1:0] want;

    // Tallies for the closing summary.
    int err_count   = 0;
    int n_loads     = 0;
    int n_rows      = 0;
    int n_reads     = 0;
    int n_ignored   = 0;
    int n_cfg       = 0;
    int n_checked   = 0;
    int n_no_route  = 0;
    int n_top_route = 0;
    int n_taken     = 0;

    // A slot gives a route only if it is in range and enabled. The folded
    // index saturates at 65535, the top of the 17-bit signed positive range.
    function automatic logic signed [ROUTE_W-1:0] fold_route(
        input logic signed [SLOT_W-1:0]   slot,
        input logic        [EXPERT_W-1:0] expert
    );
        int s;
        int v;
        s = slot;
        if (s < 0 || s >= int'(cur_adapter_count) || s >= DUT_ADAPTERS)
            return NO_ROUTE;
        if (!cur_enable_mask[s])
            return NO_ROUTE;
        v = s * int'(cur_expert_count) + int'(expert);
        if (v > int'(ROUTE_MAX))
            v = int'(ROUTE_MAX);
        return v[ROUTE_W-1:0];
    endfunction

    // Apply one accepted command to the predictor. Reads queue the value that
    // the block must return next.
    task automatic route_command(
        input logic [ACTION_W-1:0]     act,
        input logic [TOKEN_W-1:0]      tok,
        input logic signed [SLOT_W-1:0] slot,
        input logic signed [DEST_W-1:0] dest,
        input logic [EXPERT_W-1:0]     expert,
        input logic                    last,
        input logic [READ_W-1:0]       rd_pos
    );
        int k;
        int row_tok;
        int mag;
        case (act)
            ACT_LOAD: begin
                token_slot[tok] = slot;
                n_loads++;
            end
            ACT_ROW: begin
                // A top_k of zero acts as one.
                k = (cur_top_k == 0) ? 1 : int'(cur_top_k);
                row_tok = (int'(row_num) / k) % TOKEN_DEPTH;
                mag = dest;
                if (mag < 0)
                    mag = -mag;
                if (mag < DUT_ROWS)
                    scattered[mag] = fold_route(token_slot[row_tok], expert);
                // The counter restarts after a final row and otherwise wraps.
                row_num = last ? '0 : row_num + 1'b1;
                n_rows++;
            end
            ACT_READ: begin
                if (int'(rd_pos) < DUT_ROWS)
                    routes_due.push_back(scattered[rd_pos]);
                else
                    routes_due.push_back(NO_ROUTE);
                n_reads++;
            end
            default: n_ignored++;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus bookkeeping. The generator keeps its own row counter, top_k and
    // record of written entries. This record keeps every row's token loaded
    // and every read aimed at a written position.
    // ------------------------------------------------------------------------
    work_t cmd_backlog [$];
    bit    token_loaded [TOKEN_DEPTH];
    bit    pos_written [DUT_ROWS];
    int    written_list [$];
    int    gen_row     = 0;
    int    gen_top_k   = 1;
    bit    gen_wrapped = 1'b0;
    int    gen_gap_pct = 0;
    int    gen_cmds    = 0;
    int    gen_cfgs    = 0;

    function automatic work_t blank_work();
        work_t w;
        w.is_cfg  = 1'b0;
        w.reg_idx = '0;
        w.reg_val = '0;
        w.act     = ACT_UNUSED;
        w.tok     = $urandom;
        w.slot    = $urandom;
        w.dest    = $urandom;
        w.expert  = $urandom;
        w.last    = $urandom_range(0, 1);
        w.rd_pos  = $urandom;
        w.gap_pct = gen_gap_pct;
        return w;
    endfunction

    // Mostly slots in range. Negative slots and slots above the adapter
    // limit come up now and then.
    function automatic logic signed [SLOT_W-1:0] pick_slot();
        int v;
        case ($urandom_range(0, 9))
            0:       v = -1 - int'($urandom_range(0, 127));
            1:       v = $urandom_range(64, 127);
            default: v = $urandom_range(0, 63);
        endcase
        return v[SLOT_W-1:0];
    endfunction

    task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        work_t w;
        w = blank_work();
        w.is_cfg  = 1'b1;
        w.reg_idx = idx;
        w.reg_val = val;
        cmd_backlog.push_back(w);
        gen_cfgs++;
        if (idx == REG_TOP_K)
            gen_top_k = val[K_W-1:0];
    endtask

    task automatic queue_load(input int tok_v, input logic signed [SLOT_W-1:0] slot_v);
        work_t w;
        w = blank_work();
        w.act  = ACT_LOAD;
        w.tok  = tok_v[TOKEN_W-1:0];
        w.slot = slot_v;
        cmd_backlog.push_back(w);
        gen_cmds++;
        token_loaded[tok_v] = 1'b1;
    endtask

    // A row whose token has no adapter yet gets a load in front of it.
    task automatic queue_row(input int dest_v, input int expert_v, input bit last_v);
        work_t w;
        int k;
        int tok;
        int mag;
        k = (gen_top_k == 0) ? 1 : gen_top_k;
        tok = (gen_row / k) % TOKEN_DEPTH;
        if (!token_loaded[tok])
            queue_load(tok, pick_slot());
        w = blank_work();
        w.act    = ACT_ROW;
        w.dest   = dest_v[DEST_W-1:0];
        w.expert = expert_v[EXPERT_W-1:0];
        w.last   = last_v;
        cmd_backlog.push_back(w);
        gen_cmds++;
        mag = (dest_v < 0) ? -dest_v : dest_v;
        if (mag < DUT_ROWS && !pos_written[mag]) begin
            pos_written[mag] = 1'b1;
            written_list.push_back(mag);
        end
        if (last_v) begin
            gen_row = 0;
        end else begin
            if (gen_row == 1023)
                gen_wrapped = 1'b1;
            gen_row = (gen_row + 1) % 1024;
        end
    endtask

    task automatic queue_read(input int pos);
        work_t w;
        w = blank_work();
        w.act    = ACT_READ;
        w.rd_pos = pos[READ_W-1:0];
        cmd_backlog.push_back(w);
        gen_cmds++;
    endtask

    task automatic queue_noise();
        work_t w;
        w = blank_work();
        cmd_backlog.push_back(w);
        gen_cmds++;
    endtask

    // Batches of rows with random content, mixed with loads of random tokens,
    // reads of written positions and some unused action codes. Unused codes
    // do not count toward n.
    task automatic random_mix(input int n, input int row_pct, input int final_pct);
        int done;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 99) < row_pct || written_list.size() == 0) begin
                queue_row(int'($urandom_range(0, 2046)) - 1023, $urandom_range(0, 1023),
                          $urandom_range(0, 99) < final_pct);
                done++;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        queue_load($urandom_range(0, 1023), pick_slot());
                        done++;
                    end
                    9: queue_noise();
                    default: begin
                        queue_read(written_list[$urandom_range(0, written_list.size() - 1)]);
                        done++;
                    end
                endcase
            end
        end
    endtask

    // Split a phase into chunks. Each chunk has its own idle density, so that
    // busy stretches with no idling sit between stretches with frequent gaps.
    task automatic random_phase(input int n, input int row_pct, input int final_pct);
        int left;
        int chunk;
        left = n;
        while (left > 0) begin
            chunk = (left > 40) ? 40 : left;
            case ($urandom_range(0, 3))
                0:       gen_gap_pct = 0;
                1:       gen_gap_pct = 8;
                2:       gen_gap_pct = 25;
                default: gen_gap_pct = 50;
            endcase
            random_mix(chunk, row_pct, final_pct);
            left -= chunk;
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_mask();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // Driver. It takes entries from the backlog in order. A command holds
    // start high until the block takes it. A register write waits until the
    // block has gone quiet. Random idle bursts sit in front of commands.
    // ------------------------------------------------------------------------
    work_t head;
    int    gap_left  = 0;
    bit    gap_done  = 1'b0;
    int    quiet_cnt = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start         <= 1'b0;
            action        <= ACT_LOAD;
            token_index   <= '0;
            adapter_slot  <= '0;
            dest_position <= '0;
            expert_id     <= '0;
            final_row     <= 1'b0;
            read_position <= '0;
            cfg_valid     <= 1'b0;
            cfg_index     <= '0;
            cfg_data      <= '0;
            gap_left      <= 0;
            gap_done      <= 1'b0;
            quiet_cnt     <= 0;
        end else begin
            if (cmd_fire)
                quiet_cnt <= 0;
            else if (quiet_cnt < 1000)
                quiet_cnt <= quiet_cnt + 1;

            if (cfg_valid) begin
                if (cfg_ready)
                    cfg_valid <= 1'b0;
            end else if (start && !cmd_fire) begin
                // The block is still busy. Hold the command in place.
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_backlog.size() == 0) begin
                start <= 1'b0;
            end else if (cmd_backlog[0].is_cfg) begin
                // Registers change only while the block is quiet: no command
                // in flight, no read result owed and the divider finished.
                start <= 1'b0;
                if (!cmd_fire && !busy && quiet_cnt >= SETTLE_CYCLES &&
                    routes_due.size() == 0) begin
                    head = cmd_backlog.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= head.reg_idx;
                    cfg_data  <= head.reg_val;
                end
            end else if (!gap_done && $urandom_range(0, 99) < cmd_backlog[0].gap_pct) begin
                // This cycle starts an idle burst.
                start    <= 1'b0;
                gap_left <= $urandom_range(0, 12);
                gap_done <= 1'b1;
            end else begin
                head = cmd_backlog.pop_front();
                start         <= 1'b1;
                action        <= head.act;
                token_index   <= head.tok;
                adapter_slot  <= head.slot;
                dest_position <= head.dest;
                expert_id     <= head.expert;
                final_row     <= head.last;
                read_position <= head.rd_pos;
                gap_done      <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. It checks each result against the oldest expectation, then
    // applies the register writes and commands of this edge to the predictor.
    // A read result never comes at the edge of its own transfer, so the
    // order of the two steps does not matter.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid) begin
                if (routes_due.size() == 0) begin
                    $error("routed_index: expected no result, actual %0d", routed_index);
                    err_count++;
                end else begin
                    want = routes_due.pop_front();
                    n_checked++;
                    if (want == NO_ROUTE)
                        n_no_route++;
                    if (want == ROUTE_MAX[ROUTE_W-1:0])
                        n_top_route++;
                    if (routed_index !== want) begin
                        $error("routed_index: expected %0d, actual %0d", want, routed_index);
                        err_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ADAPTER_COUNT: cur_adapter_count = cfg_data[ACOUNT_W-1:0];
                    REG_ENABLE_MASK:   cur_enable_mask   = cfg_data[MASK_W-1:0];
                    REG_TOP_K:         cur_top_k         = cfg_data[K_W-1:0];
                    REG_EXPERT_COUNT:  cur_expert_count  = cfg_data[ECOUNT_W-1:0];
                    default: ;
                endcase
                n_cfg++;
            end
            if (cmd_fire) begin
                route_command(action, token_index, adapter_slot, dest_position,
                              expert_id, final_row, read_position);
                n_taken++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run. The whole backlog is built up front. The run
    // then waits until every command and write has gone through and every
    // read has been answered.
    // ------------------------------------------------------------------------
    initial begin
        int guard;

        // Directed part at the widest settings. These cover the largest exact
        // index, slot zero, the most negative slot, a slot above the adapter
        // limit, a slot of minus one, the largest destination, the extremes of the
        // expert, a final row, and an unused action code.
        gen_gap_pct = 20;
        queue_cfg(REG_ADAPTER_COUNT, 64'd64);
        queue_cfg(REG_ENABLE_MASK, '1);
        queue_cfg(REG_TOP_K, 64'd1);
        queue_cfg(REG_EXPERT_COUNT, 64'd1024);
        queue_load(0, 8'sd63);
        queue_load(1, 8'sd0);
        queue_load(2, -8'sd128);
        queue_load(3, 8'sd127);
        queue_load(4, -8'sd1);
        queue_load(1023, 8'sd5);
        queue_row(1023, 1023, 1'b0);
        queue_row(-1, 0, 1'b0);
        queue_row(0, 512, 1'b0);
        queue_row(-512, 1, 1'b0);
        queue_row(2, 1, 1'b1);
        queue_read(1023);
        queue_read(1);
        queue_read(0);
        queue_read(512);
        queue_read(2);
        queue_noise();

        // Directed part with a top_k of zero and an expert count large enough
        // that the folded index saturates. The slot at the adapter count is
        // out of range, and a disabled slot below it gives no route.
        queue_cfg(REG_ADAPTER_COUNT, 64'd40);
        queue_cfg(REG_ENABLE_MASK, (random_mask() | (64'd1 << 35) | 64'd1) & ~(64'd1 << 39));
        queue_cfg(REG_TOP_K, 64'd0);
        queue_cfg(REG_EXPERT_COUNT, 64'd2047);
        queue_load(0, 8'sd35);
        queue_load(1, 8'sd0);
        queue_load(2, 8'sd40);
        queue_load(3, 8'sd39);
        queue_row(10, 7, 1'b0);
        queue_row(-11, 1023, 1'b0);
        queue_row(12, 0, 1'b0);
        queue_row(-1023, 5, 1'b1);
        queue_read(10);
        queue_read(11);
        queue_read(12);
        queue_read(1023);

        // Random phases with several register settings.
        queue_cfg(REG_ADAPTER_COUNT, 64'd64);
        queue_cfg(REG_ENABLE_MASK, random_mask());
        queue_cfg(REG_TOP_K, $urandom_range(1, 8));
        queue_cfg(REG_EXPERT_COUNT, $urandom_range(1, 1024));
        random_phase(200, 55, 6);

        // No slot is valid and no slot is enabled. Every row gives no route.
        queue_cfg(REG_ADAPTER_COUNT, 64'd0);
        queue_cfg(REG_ENABLE_MASK, 64'd0);
        queue_cfg(REG_TOP_K, 64'd64);
        queue_cfg(REG_EXPERT_COUNT, 64'd1);
        random_phase(100, 55, 4);

        // A long run of rows with no final row, so that the row counter
        // wraps. A top_k of 64 keeps the set of tokens small.
        queue_cfg(REG_ADAPTER_COUNT, $urandom_range(1, 64));
        queue_cfg(REG_ENABLE_MASK, random_mask());
        queue_cfg(REG_TOP_K, 64'd64);
        queue_cfg(REG_EXPERT_COUNT, 64'd1024);
        gen_wrapped = 1'b0;
        while (!gen_wrapped)
            random_phase(40, 88, 0);

        queue_cfg(REG_ADAPTER_COUNT, 64'd64);
        queue_cfg(REG_ENABLE_MASK, '1);
        queue_cfg(REG_TOP_K, 64'd1);
        queue_cfg(REG_EXPERT_COUNT, 64'd1);
        random_phase(200, 55, 6);

        queue_cfg(REG_ADAPTER_COUNT, $urandom_range(1, 64));
        queue_cfg(REG_ENABLE_MASK, random_mask());
        queue_cfg(REG_TOP_K, $urandom_range(1, 64));
        queue_cfg(REG_EXPERT_COUNT, $urandom_range(1, 1024));
        random_phase(100, 55, 4);

        // The last stretch runs with no idling at all.
        gen_gap_pct = 0;
        random_mix(150, 55, 4);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (n_taken < gen_cmds || n_cfg < gen_cfgs)
            @(posedge clk);
        guard = 0;
        while (routes_due.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        // Let any stray result show up before the verdict.
        repeat (SETTLE_CYCLES + 8) @(posedge clk);
        if (routes_due.size() != 0) begin
            $error("routed_index: %0d expected results never arrived", routes_due.size());
            err_count++;
        end

        $display("Covered %0d loads, %0d rows, %0d reads, %0d ignored commands, %0d writes.",
                 n_loads, n_rows, n_reads, n_ignored, n_cfg);
        $display("Checked %0d routing indexes: %0d without a route, %0d at the top value.",
                 n_checked, n_no_route, n_top_route);
        if (err_count == 0)
            $display("expert_adapter_index_scatter_top: match");
        else
            $display("expert_adapter_index_scatter_top: mismatch");
        $finish;
    end

    // Timeout guard. A correct run with the longest idling ends well inside
    // this time.
    initial begin
        #8_000_000;
        $display("expert_adapter_index_scatter_top: mismatch");
        $finish;
    end

endmodule
